// ===== rtl/efb_pkg.sv =====
package efb_pkg;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Widths of the configuration index and of the frame length.
	localparam int CFG_IDX_W  = 1;
	localparam int LEN_W      = 10;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ESCAPE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOST   = 1'b1;

	// Request type codes carried in the input tuser.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	// Framing and checksum constants.
	localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
	localparam logic [7:0]  ESC_RESET   = 8'd27;
	localparam logic [7:0]  HOST_RESET  = 8'd0;
	localparam logic [15:0] CRC_SEED    = 16'h7E7E;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// Classification of one accepted request.
	typedef enum logic [1:0] {
		KIND_START,
		KIND_DATA,
		KIND_ERR
	} kind_t;

	// Command handed from the front to the back.
	typedef struct packed {
		kind_t      kind;
		logic       fin;
		logic [7:0] dest;
		logic [7:0] stat;
		logic [7:0] plen;
		logic [7:0] data;
	} cmd_t;

	// Position of the back end within one command.
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_FLAG0,
		PH_FLAG1,
		PH_DEST,
		PH_HOST,
		PH_STAT,
		PH_LEN,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI,
		PH_ERR
	} phase_t;

	// Shift one byte into the checksum, most significant bit first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		logic        top;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			top = c[15];
			c = {c[14:0], b[i]};
			if (top) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/escaped_frame_builder_crc16.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: dest, status, length, data; tuser: type
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: byte, frame length; tuser: run end, error
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// The back end emits one frame byte per clock while a request is queued and the output is not
// stalled; a payload request gives one or two bytes, a start request six to ten, and a frame end two to four more.
// A two-entry request queue lets the input keep accepting while bytes are still draining.
// Reset is asynchronous and needs no clearing pass; cfg_ready is always high.
// Output stalls hold the output register and, once the queue fills, the input.
module escaped_frame_builder_crc16
	import efb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // dest_addr, frame_status, payload_len, data_byte
	input  logic                 s_axis_tuser,   // req_type
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // out_byte, frame_length, 6 zero bits
	output logic                 m_axis_tlast,   // frame_end
	output logic [1:0]           m_axis_tuser,   // run_last, error
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] esc_q;
	logic [7:0] host_q;
	logic       push, pop, q_full, head_valid;
	cmd_t       push_cmd, head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= ESC_RESET;
			host_q <= HOST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IDX_ESCAPE: esc_q  <= cfg_data;
				CFG_IDX_HOST:   host_q <= cfg_data;
				default:        esc_q  <= esc_q;
			endcase
		end
	end

	efb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	efb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	efb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.esc_byte      (esc_q),
		.host_addr     (host_q),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== rtl/efb_front.sv =====
module efb_front
	import efb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // dest_addr, frame_status, payload_len, data_byte
	input  logic        s_axis_tuser,   // req_type
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic       open_q;
	logic [7:0] left_q;
	logic       accept;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign push          = accept;

	// Classify the request against the frame that is currently open.
	always_comb begin
		push_cmd.dest = s_axis_tdata[7:0];
		push_cmd.stat = s_axis_tdata[15:8];
		push_cmd.plen = s_axis_tdata[23:16];
		push_cmd.data = s_axis_tdata[31:24];
		push_cmd.kind = KIND_ERR;
		push_cmd.fin  = 1'b0;
		if (s_axis_tuser == REQ_START && !open_q) begin
			push_cmd.kind = KIND_START;
			push_cmd.fin  = (s_axis_tdata[23:16] == 8'd0);
		end else if (s_axis_tuser == REQ_DATA && open_q) begin
			push_cmd.kind = KIND_DATA;
			push_cmd.fin  = (left_q == 8'd1);
		end
	end

	// Track the open frame and the payload bytes still owed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
		end else if (accept) begin
			if (push_cmd.kind == KIND_START) begin
				open_q <= !push_cmd.fin;
				left_q <= push_cmd.plen;
			end else if (push_cmd.kind == KIND_DATA) begin
				open_q <= !push_cmd.fin;
				left_q <= left_q - 8'd1;
			end
		end
	end

	// A request is never classified as data while no frame is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !open_q |-> push_cmd.kind != KIND_DATA)
		else $error("data command issued outside a frame");

	// A request that finishes a frame leaves the frame closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && push_cmd.fin |=> !open_q)
		else $error("frame still open after its last request");

	// An open frame always owes at least one payload byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> left_q != 8'd0)
		else $error("open frame with no payload bytes left");

endmodule

// ===== rtl/efb_queue.sv =====
module efb_queue
	import efb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage needs no reset; only written slots are ever read.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/efb_back.sv =====
module efb_back
	import efb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head,
	input  logic [7:0]  esc_byte,
	input  logic [7:0]  host_addr,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_byte, frame_length, 6 zero bits
	output logic        m_axis_tlast,   // frame_end
	output logic [1:0]  m_axis_tuser    // run_last, error
);

	phase_t           phase_q, phase_d, cur_phase, next_phase;
	logic             esc_done_q, esc_done_d;
	logic [15:0]      crc_q, crc_d;
	logic [LEN_W-1:0] count_q, count_d, count_plus;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_last_q, out_end_q, out_err_q;

	logic [7:0]       byte_sel, emit_byte;
	logic             crc_phase, esc_phase, send_esc, fire, item_last;

	assign count_plus = count_q + 1'b1;
	assign fire       = head_valid && (!out_valid_q || m_axis_tready);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			esc_done_q <= 1'b0;
			crc_q      <= CRC_SEED;
			count_q    <= '0;
		end else begin
			phase_q    <= phase_d;
			esc_done_q <= esc_done_d;
			crc_q      <= crc_d;
			count_q    <= count_d;
		end
	end

	// Pick the byte of the current phase and decide whether it needs an escape.
	always_comb begin
		cur_phase = phase_q;
		if (phase_q == PH_IDLE) begin
			case (head.kind)
				KIND_START: cur_phase = PH_FLAG0;
				KIND_DATA:  cur_phase = PH_DATA;
				default:    cur_phase = PH_ERR;
			endcase
		end

		byte_sel   = 8'd0;
		next_phase = PH_IDLE;
		case (cur_phase)
			PH_FLAG0: begin
				byte_sel   = FLAG_BYTE;
				next_phase = PH_FLAG1;
			end
			PH_FLAG1: begin
				byte_sel   = FLAG_BYTE;
				next_phase = PH_DEST;
			end
			PH_DEST: begin
				byte_sel   = head.dest;
				next_phase = PH_HOST;
			end
			PH_HOST: begin
				byte_sel   = host_addr;
				next_phase = PH_STAT;
			end
			PH_STAT: begin
				byte_sel   = head.stat;
				next_phase = PH_LEN;
			end
			PH_LEN: begin
				byte_sel   = head.plen;
				next_phase = head.fin ? PH_CRC_LO : PH_IDLE;
			end
			PH_DATA: begin
				byte_sel   = head.data;
				next_phase = head.fin ? PH_CRC_LO : PH_IDLE;
			end
			PH_CRC_LO: begin
				byte_sel   = crc_q[7:0];
				next_phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				byte_sel   = crc_q[15:8];
				next_phase = PH_IDLE;
			end
			default: begin
				byte_sel   = 8'd0;
				next_phase = PH_IDLE;
			end
		endcase

		crc_phase = (cur_phase == PH_DEST) || (cur_phase == PH_HOST) ||
		            (cur_phase == PH_STAT) || (cur_phase == PH_LEN) ||
		            (cur_phase == PH_DATA);
		esc_phase = crc_phase || (cur_phase == PH_CRC_LO) || (cur_phase == PH_CRC_HI);
		send_esc  = esc_phase && !esc_done_q &&
		            ((byte_sel == esc_byte) || (byte_sel == FLAG_BYTE));
		emit_byte = send_esc ? esc_byte : byte_sel;
		item_last = !send_esc && ((cur_phase == PH_ERR) || (cur_phase == PH_CRC_HI) ||
		            (((cur_phase == PH_LEN) || (cur_phase == PH_DATA)) && !head.fin));
	end

	// Next state: one output byte per firing cycle.
	always_comb begin
		phase_d    = phase_q;
		esc_done_d = esc_done_q;
		crc_d      = crc_q;
		count_d    = count_q;
		pop        = fire && item_last;
		if (fire) begin
			if (send_esc) begin
				phase_d    = cur_phase;
				esc_done_d = 1'b1;
			end else begin
				phase_d    = next_phase;
				esc_done_d = 1'b0;
			end
			if (crc_phase) begin
				crc_d = crc_feed(crc_q, emit_byte);
			end else if (cur_phase == PH_CRC_HI && !send_esc) begin
				crc_d = CRC_SEED;
			end
			if (cur_phase != PH_ERR) begin
				count_d = (cur_phase == PH_CRC_HI && !send_esc) ? '0 : count_plus;
			end
		end
	end

	// Output register decouples the sequencer from the downstream ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= emit_byte;
			out_last_q <= item_last;
			out_end_q  <= item_last && (cur_phase == PH_CRC_HI);
			out_len_q  <= (item_last && (cur_phase == PH_CRC_HI)) ? count_plus : '0;
			out_err_q  <= (cur_phase == PH_ERR);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_len_q, out_byte_q};
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = {out_err_q, out_last_q};

	// The closing checksum byte is always the last byte of its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && m_axis_tdata[17:8] != '0)
		else $error("frame end without run end or length");

	// An error result is a lone zero byte that ends its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tuser[0] && !m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
		else $error("malformed error result");

	// An escape is always followed by its byte within the same request.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && send_esc |=> esc_done_q && phase_q != PH_IDLE)
		else $error("escape emitted without its escaped byte pending");

	// A command leaves the queue only when it is there.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");

endmodule

// ===== verif/efb_checker.sv =====
module efb_checker
	import efb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // dest_addr, frame_status, payload_len, data_byte
	input  logic                 s_axis_tuser,   // req_type
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [23:0]          m_axis_tdata,   // out_byte, frame_length, 6 zero bits
	input  logic                 m_axis_tlast,   // frame_end
	input  logic [1:0]           m_axis_tuser,   // run_last, error
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// One byte of the framed output stream.
	typedef struct packed {
		logic [7:0]       frame_byte;
		logic             run_end;
		logic             frame_end;
		logic [LEN_W-1:0] frame_len;
		logic             err;
	} frame_out_t;

	frame_out_t       expected_bytes[$];
	frame_out_t       request_bytes[14];
	int               request_cnt;

	// Shadow of the configuration and of the framer state.
	logic [7:0]       esc_val;
	logic [7:0]       host_val;
	logic [15:0]      crc_acc;
	logic [7:0]       left_cnt;
	logic             open_flag;
	logic [LEN_W-1:0] emitted;

	// Shift one byte into the checksum, MSB first.
	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int k = 0; k < 8; k++) begin
			fb  = crc[15];
			crc = {crc[14:0], b[7-k]} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	// Record one byte as produced by the current request.
	task automatic push_byte(input logic [7:0] b, input logic last_of_frame);
		emitted = emitted + 1'b1;
		request_bytes[request_cnt].frame_byte = b;
		request_bytes[request_cnt].run_end    = 1'b0;
		request_bytes[request_cnt].frame_end  = last_of_frame;
		request_bytes[request_cnt].frame_len  = last_of_frame ? emitted : '0;
		request_bytes[request_cnt].err        = 1'b0;
		request_cnt++;
	endtask

	// Emit a byte after the two flag bytes, with an escape in front where needed.
	task automatic stuff_byte(input logic [7:0] b, input logic crc_on, input logic last_of_frame);
		if (b == esc_val || b == FLAG_BYTE) begin
			push_byte(esc_val, 1'b0);
			if (crc_on) begin
				crc_acc = crc_next(crc_acc, esc_val);
			end
		end
		push_byte(b, last_of_frame);
		if (crc_on) begin
			crc_acc = crc_next(crc_acc, b);
		end
	endtask

	// Append the checksum, low byte first, and close the frame.
	task automatic close_frame();
		logic [15:0] c;
		c = crc_acc;
		stuff_byte(c[7:0], 1'b0, 1'b0);
		stuff_byte(c[15:8], 1'b0, 1'b1);
		open_flag = 1'b0;
		left_cnt  = '0;
		crc_acc   = CRC_SEED;
		emitted   = '0;
	endtask

	// Work out every byte that one accepted request causes.
	task automatic predict_request(input logic req, input logic [31:0] fields);
		logic [7:0] dest;
		logic [7:0] stat;
		logic [7:0] plen;
		logic [7:0] data;
		dest = fields[7:0];
		stat = fields[15:8];
		plen = fields[23:16];
		data = fields[31:24];
		request_cnt = 0;
		if ((req == REQ_START && open_flag) || (req == REQ_DATA && !open_flag)) begin
			// Out of sequence: a single error byte, state untouched.
			request_bytes[0] = '{frame_byte: 8'h00, run_end: 1'b1, frame_end: 1'b0,
				frame_len: '0, err: 1'b1};
			request_cnt = 1;
		end else if (req == REQ_START) begin
			open_flag = 1'b1;
			emitted   = '0;
			crc_acc   = CRC_SEED;
			push_byte(FLAG_BYTE, 1'b0);
			push_byte(FLAG_BYTE, 1'b0);
			stuff_byte(dest, 1'b1, 1'b0);
			stuff_byte(host_val, 1'b1, 1'b0);
			stuff_byte(stat, 1'b1, 1'b0);
			stuff_byte(plen, 1'b1, 1'b0);
			left_cnt = plen;
			if (left_cnt == 8'd0) begin
				close_frame();
			end
		end else begin
			stuff_byte(data, 1'b1, 1'b0);
			left_cnt = left_cnt - 1'b1;
			if (left_cnt == 8'd0) begin
				close_frame();
			end
		end
		request_bytes[request_cnt-1].run_end = 1'b1;
		for (int k = 0; k < request_cnt; k++) begin
			expected_bytes.push_back(request_bytes[k]);
		end
	endtask

	// Count a failure; only the first few are printed.
	task automatic report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		frame_out_t want;
		frame_out_t got;
		if (!arst_n) begin
			expected_bytes.delete();
			esc_val    = ESC_RESET;
			host_val   = HOST_RESET;
			crc_acc    = CRC_SEED;
			left_cnt   = '0;
			open_flag  = 1'b0;
			emitted    = '0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_ESCAPE) begin
					esc_val = cfg_data;
				end else if (cfg_index == CFG_IDX_HOST) begin
					host_val = cfg_data;
				end
			end

			// Compare each delivered byte with the oldest expected one.
			if (m_axis_tvalid && m_axis_tready) begin
				got.frame_byte = m_axis_tdata[7:0];
				got.frame_len  = m_axis_tdata[8+:LEN_W];
				got.frame_end  = m_axis_tlast;
				got.run_end    = m_axis_tuser[0];
				got.err        = m_axis_tuser[1];
				if (expected_bytes.size() == 0) begin
					report_fail($sformatf("unexpected byte %h len %0d end %b run %b err %b",
						got.frame_byte, got.frame_len, got.frame_end, got.run_end, got.err));
				end else begin
					want = expected_bytes.pop_front();
					if (got.frame_byte != want.frame_byte || got.frame_len != want.frame_len ||
					    got.frame_end != want.frame_end || got.run_end != want.run_end ||
					    got.err != want.err) begin
						report_fail($sformatf(
							"exp byte %h len %0d end %b run %b err %b, got byte %h len %0d end %b run %b err %b",
							want.frame_byte, want.frame_len, want.frame_end, want.run_end, want.err,
							got.frame_byte, got.frame_len, got.frame_end, got.run_end, got.err));
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				predict_request(s_axis_tuser, s_axis_tdata);
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
module testbench
	import efb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;
	logic                 m_axis_tlast;
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	int                   fail_count;
	int                   pending;
	int                   stall_cnt;
	idle_mode_t           idle_mode = IDLE_NONE;
	logic [7:0]           esc_cur;

	escaped_frame_builder_crc16 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	efb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random according to the current idling mode.
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECV: begin
				m_axis_tready <= ($urandom_range(0, 99) >= 77);
			end
			IDLE_BOTH: begin
				m_axis_tready <= ($urandom_range(0, 99) >= 6);
			end
			default: begin
				m_axis_tready <= 1'b1;
			end
		endcase
	end

	// Give up when nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end else begin
			stall_cnt <= 0;
		end
	end

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND: return ($urandom_range(0, 99) < 77);
			IDLE_BOTH: return ($urandom_range(0, 99) < 6);
			default:   return 1'b0;
		endcase
	endfunction

	// Random byte, biased toward the two values that get escaped.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return esc_cur;
		end else if (r == 1) begin
			return FLAG_BYTE;
		end
		return 8'($urandom);
	endfunction

	// Offer one request and hold it until it is taken. Called at a falling edge.
	task automatic send_req(input logic req, input logic [31:0] fields);
		while (sender_idles()) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= fields;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		@(negedge clk);
	endtask

	task automatic send_start(input logic [7:0] dest, input logic [7:0] stat, input logic [7:0] plen);
		send_req(REQ_START, {8'($urandom), plen, stat, dest});
	endtask

	task automatic send_data(input logic [7:0] b);
		send_req(REQ_DATA, {b, 24'($urandom)});
	endtask

	// Let every expected byte come out, then a little more for the pipeline.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(negedge clk);
	endtask

	// Write both registers while the block is idle.
	task automatic set_regs(input logic [7:0] esc, input logic [7:0] host);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? CFG_IDX_ESCAPE : CFG_IDX_HOST;
			cfg_data  <= (i == 0) ? esc : host;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		esc_cur = esc;
	endtask

	// Mostly complete frames with random content, plus stray and misplaced requests.
	task automatic run_random(input int target);
		int done;
		int len;
		done = 0;
		while (done < target) begin
			idle_mode = idle_mode_t'($urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0) begin
				send_data(pick_byte());
			end
			len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
			send_start(pick_byte(), pick_byte(), 8'(len));
			done++;
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					send_start(pick_byte(), pick_byte(), 8'($urandom));
				end
				send_data(pick_byte());
				done++;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_START;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_IDX_ESCAPE;
		cfg_data      = '0;
		esc_cur       = ESC_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests under the reset configuration.
		send_data(8'h55);                     // data with no frame open
		send_start(FLAG_BYTE, ESC_RESET, 8'd0); // empty payload, escaped header
		send_start(8'hFF, 8'h00, 8'd3);
		send_start(8'h00, 8'h00, 8'd1);       // start inside an open frame
		send_data(ESC_RESET);
		send_data(FLAG_BYTE);
		send_data(8'hFF);
		send_start(8'h00, 8'hFF, 8'd1);
		send_data(8'h00);
		send_data(8'hFF);                     // data after the frame closed
		send_start(ESC_RESET, FLAG_BYTE, 8'd2);
		send_data(FLAG_BYTE);
		send_data(FLAG_BYTE);
		run_random(26);
		wait_drain();

		// Escape at zero, host at its maximum.
		idle_mode = IDLE_NONE;
		set_regs(8'h00, 8'hFF);
		send_start(8'h00, FLAG_BYTE, 8'd0);
		run_random(26);
		wait_drain();

		// Escape at its maximum, with one frame of the longest payload.
		idle_mode = IDLE_NONE;
		set_regs(8'hFF, FLAG_BYTE);
		send_start(8'hFF, 8'hFF, 8'd0);
		idle_mode = idle_mode_t'($urandom_range(0, 3));
		send_start(pick_byte(), pick_byte(), 8'd255);
		for (int k = 0; k < 255; k++) begin
			if (k % 64 == 0) begin
				idle_mode = idle_mode_t'($urandom_range(0, 3));
			end
			send_data(pick_byte());
		end
		run_random(26);
		wait_drain();

		// Escape equal to the flag byte.
		idle_mode = IDLE_NONE;
		set_regs(FLAG_BYTE, ESC_RESET);
		send_start(FLAG_BYTE, 8'h00, 8'd0);
		run_random(26);
		wait_drain();

		// Random escape and host address.
		idle_mode = IDLE_NONE;
		set_regs(8'($urandom), 8'($urandom));
		send_start(esc_cur, FLAG_BYTE, 8'd0);
		run_random(26);
		wait_drain();

		// Back to the reset values, written explicitly.
		idle_mode = IDLE_NONE;
		set_regs(ESC_RESET, HOST_RESET);
		run_random(26);
		wait_drain();

		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
